// File: rtl/core/bmse_pkg.sv
// Shared constants, controller states and control/status bundles for the batch MSE unit.
package bmse_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int ROW_LEN_W  = 9;
    localparam int ROWS_W     = 11;
    localparam int SQ_W       = 32;
    localparam int ROW_SUM_W  = 40;
    localparam int BATCH_W    = 42;
    localparam int RESULT_W   = 32;
    localparam int ROOT_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [ROW_LEN_W-1:0] MAX_ROW_LEN = ROW_LEN_W'(256);
    localparam logic [ROWS_W-1:0]    MAX_ROWS    = ROWS_W'(1024);

    localparam logic [CFG_IDX_W-1:0] REG_ERROR_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_TOTAL  = CFG_IDX_W'(2);

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_FLUSH,
        ST_ROW_LOAD,
        ST_ROW_DIV,
        ST_ROOT_LOAD,
        ST_ROOT,
        ST_ROW_ADD,
        ST_BATCH_LOAD,
        ST_BATCH_DIV,
        ST_EMIT
    } bmse_state_t;

    typedef struct packed {
        logic acc_en;
        logic row_clear;
        logic div_start;
        logic div_batch;
        logic sqrt_start;
        logic batch_add;
        logic batch_root;
        logic batch_clear;
        logic out_load;
    } bmse_cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } bmse_status_t;

endpackage

// File: rtl/core/bmse_div.sv
// Restoring divider, one quotient bit per cycle.
module bmse_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [bmse_pkg::BATCH_W-1:0]   dividend,
    input  logic [bmse_pkg::ROWS_W-1:0]    divisor,
    output logic                           done,
    output logic [bmse_pkg::BATCH_W-1:0]   quotient
);
    import bmse_pkg::*;

    localparam int CNT_W = $clog2(BATCH_W);

    logic [BATCH_W-1:0] quo_reg, quo_next;
    logic [ROWS_W-1:0]  rem_reg, rem_next;
    logic [ROWS_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [ROWS_W:0]    trial;
    logic               ge;

    always_comb begin
        trial     = {rem_reg, quo_reg[BATCH_W-1]};
        ge        = (trial >= {1'b0, dvs_reg});
        rem_next  = ge ? ROWS_W'(trial - {1'b0, dvs_reg}) : trial[ROWS_W-1:0];
        quo_next  = {quo_reg[BATCH_W-2:0], ge};
        cnt_next  = cnt_reg + CNT_W'(1);
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg && cnt_reg == CNT_W'(BATCH_W - 1)) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/bmse_sqrt.sv
// Integer square root, one root bit per cycle.
module bmse_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [bmse_pkg::RESULT_W-1:0] radicand,
    output logic                          done,
    output logic [bmse_pkg::ROOT_W-1:0]   root
);
    import bmse_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 1;

    logic [RESULT_W-1:0] rad_reg;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg, done_reg;
    logic [REM_W+1:0]    rem_sh, trial;
    logic                ge;

    always_comb begin
        rem_sh    = {rem_reg, rad_reg[RESULT_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        ge        = (rem_sh >= trial);
        rem_next  = ge ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
        root_next = {root_reg[ROOT_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(ROOT_W - 1));
            if (busy_reg && cnt_reg == CNT_W'(ROOT_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RESULT_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: rtl/core/bmse_dp.sv
// Datapath: squarer, row and batch accumulators, shared divider, square root, output register.
module bmse_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bmse_pkg::bmse_cmd_t             cmd,
    output bmse_pkg::bmse_status_t          status,
    input  logic [bmse_pkg::SAMPLE_W-1:0]   actual_value,
    input  logic [bmse_pkg::SAMPLE_W-1:0]   predicted_value,
    input  logic [bmse_pkg::ROW_LEN_W-1:0]  len_eff,
    input  logic [bmse_pkg::ROWS_W-1:0]     rows_eff,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bmse_pkg::RESULT_W-1:0]   out_data
);
    import bmse_pkg::*;

    logic signed [SAMPLE_W:0] diff;
    logic [SAMPLE_W-1:0]      mag;
    logic [SQ_W-1:0]          sq_reg;
    logic                     sq_vld_reg;
    logic [ROW_SUM_W-1:0]     row_sum_reg;
    logic [BATCH_W-1:0]       batch_sum_reg;
    logic [BATCH_W-1:0]       div_dividend, quotient;
    logic [ROWS_W-1:0]        div_divisor;
    logic [ROOT_W-1:0]        root;
    logic [RESULT_W-1:0]      row_value;
    logic                     div_done, sqrt_done;
    logic [RESULT_W-1:0]      out_data_reg;
    logic                     out_valid_reg;

    // |a - p| of two 16-bit signed samples fits in 16 bits unsigned
    always_comb begin
        diff = $signed({actual_value[SAMPLE_W-1], actual_value})
             - $signed({predicted_value[SAMPLE_W-1], predicted_value});
        mag  = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg <= 1'b0;
        end else begin
            sq_vld_reg <= cmd.acc_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc_en) begin
            sq_reg <= SQ_W'(mag) * SQ_W'(mag);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_sum_reg <= '0;
        end else if (cmd.row_clear) begin
            row_sum_reg <= '0;
        end else if (sq_vld_reg) begin
            row_sum_reg <= row_sum_reg + ROW_SUM_W'(sq_reg);
        end
    end

    assign row_value = cmd.batch_root ? RESULT_W'(root) : quotient[RESULT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            batch_sum_reg <= '0;
        end else if (cmd.batch_clear) begin
            batch_sum_reg <= '0;
        end else if (cmd.batch_add) begin
            batch_sum_reg <= batch_sum_reg + BATCH_W'(row_value);
        end
    end

    assign div_dividend = cmd.div_batch ? batch_sum_reg : BATCH_W'(row_sum_reg);
    assign div_divisor  = cmd.div_batch ? rows_eff : ROWS_W'(len_eff);

    bmse_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    bmse_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (quotient[RESULT_W-1:0]),
        .done     (sqrt_done),
        .root     (root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= quotient[RESULT_W-1:0];
        end
    end

    assign status.div_done  = div_done;
    assign status.sqrt_done = sqrt_done;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over an untaken result");
    a_no_add_on_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.row_clear |-> !sq_vld_reg)
        else $error("row sum cleared with a product pending");
    a_sqrt_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sqrt_start |-> $past(div_done, 2) || $past(div_done, 1))
        else $error("square root started without a fresh quotient");
`endif

endmodule

// File: rtl/core/bmse_ctrl.sv
// Controller: element and row counters, sequencing of row and batch ends.
module bmse_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            error_mode,
    input  logic [bmse_pkg::ROW_LEN_W-1:0]  len_eff,
    input  logic [bmse_pkg::ROWS_W-1:0]     rows_eff,
    input  bmse_pkg::bmse_status_t          status,
    output bmse_pkg::bmse_cmd_t             cmd
);
    import bmse_pkg::*;

    bmse_state_t           state_reg, state_next;
    logic [ROW_LEN_W-1:0]  elem_reg, elem_next, elem_inc;
    logic [ROWS_W-1:0]     row_reg, row_next, row_inc;
    logic                  root_reg, root_next;
    logic                  accept;

    assign elem_inc = elem_reg + ROW_LEN_W'(1);
    assign row_inc  = row_reg + ROWS_W'(1);
    assign accept   = (state_reg == ST_ACCUM) && in_valid;

    always_comb begin
        state_next = state_reg;
        elem_next  = elem_reg;
        row_next   = row_reg;
        root_next  = root_reg;
        case (state_reg)
            ST_ACCUM: begin
                if (accept) begin
                    if (elem_inc >= len_eff) begin
                        elem_next  = '0;
                        state_next = ST_FLUSH;
                    end else begin
                        elem_next = elem_inc;
                    end
                end
            end
            ST_FLUSH:    state_next = ST_ROW_LOAD;
            ST_ROW_LOAD: state_next = ST_ROW_DIV;
            ST_ROW_DIV: begin
                if (status.div_done) begin
                    root_next  = error_mode;
                    state_next = error_mode ? ST_ROOT_LOAD : ST_ROW_ADD;
                end
            end
            ST_ROOT_LOAD: state_next = ST_ROOT;
            ST_ROOT: begin
                if (status.sqrt_done) begin
                    state_next = ST_ROW_ADD;
                end
            end
            ST_ROW_ADD: begin
                if (row_inc >= rows_eff) begin
                    row_next   = '0;
                    state_next = ST_BATCH_LOAD;
                end else begin
                    row_next   = row_inc;
                    state_next = ST_ACCUM;
                end
            end
            ST_BATCH_LOAD: state_next = ST_BATCH_DIV;
            ST_BATCH_DIV: begin
                if (status.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_ACCUM;
                end
            end
            default: state_next = ST_ACCUM;
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.acc_en      = accept;
        cmd.batch_root  = root_reg;
        case (state_reg)
            ST_ROW_LOAD: begin
                cmd.div_start = 1'b1;
                cmd.row_clear = 1'b1;
            end
            ST_ROOT_LOAD: cmd.sqrt_start = 1'b1;
            ST_ROW_ADD:   cmd.batch_add  = 1'b1;
            ST_BATCH_LOAD: begin
                cmd.div_start   = 1'b1;
                cmd.div_batch   = 1'b1;
                cmd.batch_clear = 1'b1;
            end
            ST_EMIT: cmd.out_load = status.out_free;
            default: cmd.acc_en = accept;
        endcase
    end

    assign in_ready = (state_reg == ST_ACCUM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
            elem_reg  <= '0;
            row_reg   <= '0;
            root_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            elem_reg  <= elem_next;
            row_reg   <= row_next;
            root_reg  <= root_next;
        end
    end

`ifndef SYNTHESIS
    a_row_end_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && elem_inc >= len_eff) |=> (state_reg == ST_FLUSH))
        else $error("row end not followed by flush");
    a_elem_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_ACCUM) |-> (elem_reg == '0))
        else $error("element count nonzero outside accumulation");
    a_div_branch: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROW_DIV && status.div_done)
        |=> (state_reg == ST_ROOT_LOAD || state_reg == ST_ROW_ADD))
        else $error("row divide finished into a wrong state");
`endif

endmodule

// File: rtl/core/batch_mean_square_error_unit.sv
// Top level of the batch mean square / mean RMS error unit with its configuration registers.
//
//  channel   dir   handshake              payload
//  s_        in    s_tvalid / s_tready    s_tdata: actual_value, predicted_value
//  m_        out   m_tvalid / m_tready    m_tdata: batch_error
//  cfg_      in    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Sample pairs are taken one per cycle within a row. A row end runs a flush and the
// 42-step shared divider, plus the 16-step square root in root mode.
// A batch end adds the divide by the row count.
// Reset (aresetn low, synchronous) clears counters, sums and registers to defaults.
// The result waits in an output register; a stalled m_ side only holds the block
// at the next batch end. Configuration writes are always taken.
module batch_mean_square_error_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // [15:0] actual_value, [31:16] predicted_value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // [31:0] batch_error
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bmse_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bmse_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bmse_pkg::*;

    logic                  error_mode_reg;
    logic [ROW_LEN_W-1:0]  row_length_reg;
    logic [ROWS_W-1:0]     row_total_reg;
    logic [ROW_LEN_W-1:0]  len_eff;
    logic [ROWS_W-1:0]     rows_eff;
    bmse_cmd_t             cmd;
    bmse_status_t          status;
    logic                  cfg_xfer;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    // unknown register index: transfer taken, nothing written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_mode_reg <= 1'b0;
            row_length_reg <= ROW_LEN_W'(1);
            row_total_reg  <= ROWS_W'(1);
        end else if (cfg_xfer) begin
            case (cfg_index)
                REG_ERROR_MODE: error_mode_reg <= cfg_data[0];
                REG_ROW_LENGTH: row_length_reg <= cfg_data[ROW_LEN_W-1:0];
                REG_ROW_TOTAL:  row_total_reg  <= cfg_data[ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize clamps to the maximum
    always_comb begin
        if (row_length_reg == '0) begin
            len_eff = ROW_LEN_W'(1);
        end else if (row_length_reg > MAX_ROW_LEN) begin
            len_eff = MAX_ROW_LEN;
        end else begin
            len_eff = row_length_reg;
        end
        if (row_total_reg == '0) begin
            rows_eff = ROWS_W'(1);
        end else if (row_total_reg > MAX_ROWS) begin
            rows_eff = MAX_ROWS;
        end else begin
            rows_eff = row_total_reg;
        end
    end

    bmse_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .error_mode (error_mode_reg),
        .len_eff    (len_eff),
        .rows_eff   (rows_eff),
        .status     (status),
        .cmd        (cmd)
    );

    bmse_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .actual_value    (s_tdata[15:0]),
        .predicted_value (s_tdata[31:16]),
        .len_eff         (len_eff),
        .rows_eff        (rows_eff),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_data        (m_tdata)
    );

endmodule
